// File: rtl/slhm_pkg.sv
package slhm_pkg;

  localparam int COLOR_STOPS = 19;
  localparam int FRAC_BITS   = 16;

  localparam int SEGS       = COLOR_STOPS - 1;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int PROD_SHIFT = 40 - FRAC_BITS;

  // Capped normalized value, the value times the segment count, and the blend sum.
  localparam int V_W   = FRAC_BITS + 2;
  localparam int VS_W  = $clog2(2 * ONE * SEGS + 1);
  localparam int SEG_W = $clog2(COLOR_STOPS);
  localparam int ACC_W = VS_W + 11;
  localparam int CH_W  = 8;

  localparam int PADDR_W = 3;

  typedef enum logic {
    REG_RANGE_MIN   = 1'b0,
    REG_RANGE_SCALE = 1'b1
  } reg_idx_t;

  typedef logic [3*CH_W-1:0] rgb_t;

  // Color stops from black to white, packed as {red, green, blue}.
  function automatic rgb_t stop_color(input logic [SEG_W-1:0] idx);
    rgb_t c;
    case (idx)
      5'd0:    c = {8'd0,   8'd0,   8'd0};
      5'd1:    c = {8'd1,   8'd2,   8'd19};
      5'd2:    c = {8'd1,   8'd3,   8'd37};
      5'd3:    c = {8'd1,   8'd3,   8'd53};
      5'd4:    c = {8'd19,  8'd2,   8'd70};
      5'd5:    c = {8'd45,  8'd2,   8'd89};
      5'd6:    c = {8'd80,  8'd2,   8'd110};
      5'd7:    c = {8'd122, 8'd3,   8'd126};
      5'd8:    c = {8'd157, 8'd3,   8'd122};
      5'd9:    c = {8'd183, 8'd3,   8'd101};
      5'd10:   c = {8'd214, 8'd3,   8'd64};
      5'd11:   c = {8'd237, 8'd28,  8'd41};
      5'd12:   c = {8'd252, 8'd75,  8'd32};
      5'd13:   c = {8'd252, 8'd144, 8'd66};
      5'd14:   c = {8'd253, 8'd200, 8'd102};
      5'd15:   c = {8'd253, 8'd245, 8'd143};
      5'd16:   c = {8'd242, 8'd251, 8'd185};
      5'd17:   c = {8'd240, 8'd254, 8'd216};
      5'd18:   c = {8'd255, 8'd255, 8'd255};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/spectrum_level_to_heatmap_rgb.sv
// Heat-map pixel color for one spectrum bin level. The level is offset by
// range_min and scaled by range_scale, and the result picks a segment of a
// fixed black-to-white color table and is blended linearly between its two
// stops. Levels below range_min give black and values well above the range
// give white. The block takes one request per clock unless in_stall is high,
// through a five-stage pipeline whose stages are the offset subtract, the
// 32 by 32 scale multiply, segment selection, the per-channel blend
// multiply and the final clamp. A stalled output holds only the stages
// behind it that are full; bubbles close up.
module spectrum_level_to_heatmap_rgb (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [31:0]                in_level,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [slhm_pkg::CH_W-1:0]         out_red,
  output logic [slhm_pkg::CH_W-1:0]         out_green,
  output logic [slhm_pkg::CH_W-1:0]         out_blue,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slhm_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int VR_W  = 64 - slhm_pkg::PROD_SHIFT;
  localparam int Q_W   = slhm_pkg::VS_W - slhm_pkg::FRAC_BITS;
  localparam int CH_W  = slhm_pkg::CH_W;
  localparam int ACC_W = slhm_pkg::ACC_W;

  // Configuration registers.
  logic signed [31:0] range_min_r;
  logic [31:0]        range_scale_r;
  logic               cfg_wr;
  slhm_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = slhm_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r   <= '0;
      range_scale_r <= 32'd16777216;
    end else if (cfg_wr) begin
      case (cfg_idx)
        slhm_pkg::REG_RANGE_MIN:   range_min_r   <= pwdata;
        slhm_pkg::REG_RANGE_SCALE: range_scale_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      slhm_pkg::REG_RANGE_MIN:   prdata = range_min_r;
      slhm_pkg::REG_RANGE_SCALE: prdata = range_scale_r;
      default:                   prdata = '0;
    endcase
  end

  // Stage valids and per-stage advance.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || !out_stall;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage 1: offset. A negative difference is forced to zero, which maps to black.
  logic signed [32:0] diff;
  logic [31:0]        diff_r;
  logic [31:0]        diff_nxt;

  assign diff     = {in_level[31], in_level} - {range_min_r[31], range_min_r};
  assign diff_nxt = diff[32] ? '0 : diff[31:0];

  always_ff @(posedge clk) begin
    if (en1) diff_r <= diff_nxt;
  end

  // Stage 2: scale multiply.
  logic [63:0]     prod;
  logic [VR_W-1:0] vraw_r;

  assign prod = {32'd0, diff_r} * {32'd0, range_scale_r};

  always_ff @(posedge clk) begin
    if (en2) vraw_r <= prod[63:slhm_pkg::PROD_SHIFT];
  end

  // Stage 3: cap at 2.0, then pick the segment whose upper edge first covers the value.
  logic [slhm_pkg::V_W-1:0]   v;
  logic [slhm_pkg::VS_W-1:0]  vs;
  logic [Q_W-1:0]             q;
  logic [Q_W-1:0]             qc;
  logic [slhm_pkg::SEG_W-1:0] seg_nxt, seg_r;
  logic [slhm_pkg::SEG_W-1:0] seg_m1;
  logic [slhm_pkg::VS_W-1:0]  num_nxt, num_r;

  always_comb begin
    if (vraw_r > VR_W'(2 * slhm_pkg::ONE)) begin
      v = slhm_pkg::V_W'(2 * slhm_pkg::ONE);
    end else begin
      v = vraw_r[slhm_pkg::V_W-1:0];
    end
    vs = slhm_pkg::VS_W'(v) * slhm_pkg::VS_W'(slhm_pkg::SEGS);
    q  = vs[slhm_pkg::VS_W-1:slhm_pkg::FRAC_BITS];
    qc = q + Q_W'(|vs[slhm_pkg::FRAC_BITS-1:0]);
    if (qc == '0) begin
      seg_nxt = slhm_pkg::SEG_W'(1);
    end else if (qc > Q_W'(slhm_pkg::SEGS)) begin
      seg_nxt = slhm_pkg::SEG_W'(slhm_pkg::SEGS);
    end else begin
      seg_nxt = qc[slhm_pkg::SEG_W-1:0];
    end
    seg_m1  = seg_nxt - slhm_pkg::SEG_W'(1);
    num_nxt = vs - (slhm_pkg::VS_W'(seg_m1) << slhm_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      seg_r <= seg_nxt;
      num_r <= num_nxt;
    end
  end

  // Stage 4: blend between the two stops of the segment.
  slhm_pkg::rgb_t           lo_rgb, hi_rgb;
  logic signed [ACC_W-1:0]  acc_nxt [3];
  logic signed [ACC_W-1:0]  acc_r   [3];
  logic signed [CH_W:0]     delta;
  logic signed [ACC_W-1:0]  base;

  always_comb begin
    lo_rgb = slhm_pkg::stop_color(seg_r - slhm_pkg::SEG_W'(1));
    hi_rgb = slhm_pkg::stop_color(seg_r);
    delta  = '0;
    base   = '0;
    for (int ch = 0; ch < 3; ch++) begin
      delta = $signed({1'b0, hi_rgb[ch*CH_W +: CH_W]})
            - $signed({1'b0, lo_rgb[ch*CH_W +: CH_W]});
      base  = $signed(ACC_W'(lo_rgb[ch*CH_W +: CH_W])) <<< slhm_pkg::FRAC_BITS;
      acc_nxt[ch] = base + $signed({{(ACC_W-slhm_pkg::VS_W){1'b0}}, num_r})
                         * ACC_W'(delta);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc_r[ch] <= acc_nxt[ch];
      end
    end
  end

  // Stage 5: truncate and clamp to 0..255.
  logic [CH_W-1:0] chan_nxt [3];
  logic [CH_W-1:0] chan_r   [3];
  logic [ACC_W-slhm_pkg::FRAC_BITS-1:0] whole;

  always_comb begin
    whole = '0;
    for (int ch = 0; ch < 3; ch++) begin
      whole = acc_r[ch][ACC_W-1:slhm_pkg::FRAC_BITS];
      if (acc_r[ch][ACC_W-1] || acc_r[ch] == '0) begin
        chan_nxt[ch] = '0;
      end else if (|whole[ACC_W-slhm_pkg::FRAC_BITS-1:CH_W]) begin
        chan_nxt[ch] = '1;
      end else begin
        chan_nxt[ch] = whole[CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int ch = 0; ch < 3; ch++) begin
        chan_r[ch] <= chan_nxt[ch];
      end
    end
  end

  assign out_valid = v5_r;
  assign out_red   = chan_r[2];
  assign out_green = chan_r[1];
  assign out_blue  = chan_r[0];

  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (seg_r != '0 && seg_r <= slhm_pkg::SEG_W'(slhm_pkg::SEGS)))
    else $error("segment index out of range");

  a_num_inner: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && seg_r != slhm_pkg::SEG_W'(slhm_pkg::SEGS))
      |-> num_r <= slhm_pkg::VS_W'(slhm_pkg::ONE))
    else $error("blend fraction exceeds one inside the table");

  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !en2) |=> (v1_r && $stable(diff_r)))
    else $error("stalled first stage lost or changed its request");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && v5_r && out_stall))
    else $error("input stalled while the pipeline has a bubble");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct {
    logic signed [31:0] level;
    pixel_t             px;
  } pending_pixel_t;

  localparam longint LVL_MAX = 64'sh7FFF_FFFF;
  localparam longint LVL_MIN = -64'sh8000_0000;

  // Holds the expected colors of accepted requests and checks results in order.
  class heatmap_scoreboard;
    logic signed [31:0] range_min;
    logic [31:0]        range_scale;
    int                 errors;
    local pending_pixel_t expected_pixels[$];
    local int             stop_tab[slhm_pkg::COLOR_STOPS][3];

    function new();
      range_min   = '0;
      range_scale = 32'h0100_0000;
      errors      = 0;
      stop_tab = '{'{0, 0, 0}, '{1, 2, 19}, '{1, 3, 37}, '{1, 3, 53},
                   '{19, 2, 70}, '{45, 2, 89}, '{80, 2, 110}, '{122, 3, 126},
                   '{157, 3, 122}, '{183, 3, 101}, '{214, 3, 64}, '{237, 28, 41},
                   '{252, 75, 32}, '{252, 144, 66}, '{253, 200, 102},
                   '{253, 245, 143}, '{242, 251, 185}, '{240, 254, 216},
                   '{255, 255, 255}};
    endfunction

    function logic [7:0] blend(int lo, int hi, u64_t num);
      longint acc;
      acc = longint'(lo) * slhm_pkg::ONE + longint'(num) * (hi - lo);
      if (acc <= 0) return 8'd0;
      acc = acc >>> slhm_pkg::FRAC_BITS;
      return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    function pixel_t heat_color(logic signed [31:0] level);
      longint diff;
      u64_t   v;
      u64_t   num;
      int     seg;
      int     c;
      pixel_t px;
      diff = longint'(level) - longint'(range_min);
      if (diff < 0) return '0;
      v = (u64_t'(diff) * u64_t'({32'd0, range_scale})) >> slhm_pkg::PROD_SHIFT;
      if (v > 2 * slhm_pkg::ONE) v = 2 * slhm_pkg::ONE;
      // Scan downward so the lowest qualifying segment wins.
      seg = slhm_pkg::SEGS;
      for (c = slhm_pkg::SEGS; c >= 1; c--) begin
        if (v * slhm_pkg::SEGS <= u64_t'(c) * slhm_pkg::ONE) seg = c;
      end
      num = v * slhm_pkg::SEGS - u64_t'(seg - 1) * slhm_pkg::ONE;
      px.red   = blend(stop_tab[seg-1][0], stop_tab[seg][0], num);
      px.green = blend(stop_tab[seg-1][1], stop_tab[seg][1], num);
      px.blue  = blend(stop_tab[seg-1][2], stop_tab[seg][2], num);
      return px;
    endfunction

    function void note_level(logic signed [31:0] level);
      pending_pixel_t e;
      e.level = level;
      e.px    = heat_color(level);
      expected_pixels.push_back(e);
    endfunction

    function void check_pixel(pixel_t got);
      pending_pixel_t e;
      if (expected_pixels.size() == 0) begin
        if (errors < 10)
          $display("unexpected pixel %0d/%0d/%0d", got.red, got.green, got.blue);
        errors++;
        return;
      end
      e = expected_pixels.pop_front();
      if (got.red !== e.px.red || got.green !== e.px.green || got.blue !== e.px.blue) begin
        if (errors < 10)
          $display("pixel mismatch for level %h: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                   e.level, e.px.red, e.px.green, e.px.blue, got.red, got.green, got.blue);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void close_out();
      if (expected_pixels.size() != 0) begin
        $display("%0d expected pixels never arrived", expected_pixels.size());
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [31:0]           in_level = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [slhm_pkg::CH_W-1:0]    out_red;
  logic [slhm_pkg::CH_W-1:0]    out_green;
  logic [slhm_pkg::CH_W-1:0]    out_blue;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [slhm_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  logic               calm = 1'b0;
  logic signed [31:0] cur_min = '0;
  logic [31:0]        cur_scale = 32'h0100_0000;

  heatmap_scoreboard sb = new();

  spectrum_level_to_heatmap_rgb dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_level (in_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_level(in_level);
      if (out_valid && !out_stall) sb.check_pixel({out_red, out_green, out_blue});
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 34);
  end

  task automatic drive_level(logic [31:0] lvl);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid = 1'b0;
      in_level = $urandom;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_level = lvl;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(slhm_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = slhm_pkg::PADDR_W'(idx) << 2;
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_range(logic [31:0] rmin, logic [31:0] scl);
    drain();
    cfg_write(slhm_pkg::REG_RANGE_MIN, rmin);
    cfg_write(slhm_pkg::REG_RANGE_SCALE, scl);
    cur_min           = rmin;
    cur_scale         = scl;
    sb.range_min      = rmin;
    sb.range_scale    = scl;
  endtask

  // Most levels land inside or just outside the display range; the rest are
  // arbitrary words.
  function automatic logic [31:0] pick_level(logic signed [31:0] rmin, logic [31:0] scl);
    longint target_v;
    longint diff;
    longint lvl;
    if (scl == 0 || $urandom_range(99) < 20) return $urandom;
    target_v = $urandom_range(slhm_pkg::ONE * 6 / 5, 0);
    diff = (target_v << slhm_pkg::PROD_SHIFT) / longint'({32'd0, scl})
         + $urandom_range(2);
    if ($urandom_range(9) == 0) diff = -diff - 1;
    lvl = longint'(rmin) + diff;
    if (lvl > LVL_MAX) lvl = LVL_MAX;
    if (lvl < LVL_MIN) lvl = LVL_MIN;
    return lvl[31:0];
  endfunction

  task automatic random_levels(int n, int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain();
      drive_level(pick_level(cur_min, cur_scale));
    end
  endtask

  initial begin
    logic [31:0] edge_levels[17];
    logic [31:0] rmin;
    logic [31:0] scl;
    edge_levels = '{32'd0, 32'd1, 32'd3640, 32'd3641, 32'd61895, 32'd61896,
                    32'd65535, 32'd65536, 32'd65537, 32'd69176, 32'd69177,
                    32'd131072, 32'd131073, 32'hFFFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h0000_8000};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset range: the level maps straight to the normalized value.
    foreach (edge_levels[i]) drive_level(edge_levels[i]);
    random_levels(130, -1);

    set_range(32'h8000_0000, 32'hFFFF_FFFF);
    drive_level(32'h8000_0000);
    drive_level(32'h7FFF_FFFF);
    random_levels(60, -1);

    // Zero scale: every level at or above the minimum is black too.
    set_range(32'h7FFF_FFFF, 32'd0);
    drive_level(32'h7FFF_FFFF);
    drive_level(32'h8000_0000);
    random_levels(60, -1);

    calm = 1'b1;
    set_range(-(32'sd100 <<< 16), 32'd167772);
    random_levels(150, -1);
    calm = 1'b0;

    for (int p = 0; p < 6; p++) begin
      rmin = (32'($urandom_range(250)) - 32'd200) << 16 | 32'($urandom_range(65535));
      scl  = ($urandom_range(9) == 0) ? $urandom
                                      : $urandom_range(32'h0400_0000, 32'h0001_0000);
      set_range(rmin, scl);
      random_levels(110, (p == 1) ? 70 : -1);
    end

    drain();
    sb.close_out();
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
